// File: hw/rtl/tfp_pkg.sv
package tfp_pkg;

    localparam int VALUE_W  = 48;
    localparam int WORD_W   = 32;
    localparam int PROD_W   = VALUE_W + 7;
    localparam int FRAC_W   = 16;
    localparam int IDX_W    = 5;
    localparam int NUM_VALS = 3;

    localparam logic [7:0] FRAME_HEAD     = 8'hAA;
    localparam logic [7:0] DEST_RESET     = 8'hFF;
    localparam logic [6:0] SCALE_FACTOR   = 7'd100;
    localparam logic [7:0] LEN_NO_COUNT   = 8'd12;
    localparam logic [7:0] LEN_WITH_COUNT = 8'd16;

    localparam logic [IDX_W-1:0] POS_HEAD   = 5'd0;
    localparam logic [IDX_W-1:0] POS_DEST   = 5'd1;
    localparam logic [IDX_W-1:0] POS_ID     = 5'd2;
    localparam logic [IDX_W-1:0] POS_LEN    = 5'd3;
    localparam logic [IDX_W-1:0] HDR_BYTES  = 5'd4;
    localparam logic [IDX_W-1:0] SUM_POS_NO_COUNT   = 5'd16;
    localparam logic [IDX_W-1:0] SUM_POS_WITH_COUNT = 5'd20;

    localparam logic [1:0] CONV_LAST = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic             load;
        logic             conv_go;
        logic [1:0]       conv_idx;
        logic             wr_en;
        logic [1:0]       wr_idx;
        logic             emit;
        logic [IDX_W-1:0] byte_idx;
    } cmd_t;

    typedef struct packed {
        logic has_count;
        logic out_free;
    } sts_t;

endpackage

// File: hw/rtl/tfp_ctrl.sv
module tfp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tfp_pkg::sts_t sts,
    output tfp_pkg::cmd_t cmd
);
    import tfp_pkg::*;

    state_t           state_reg, state_next;
    logic [1:0]       conv_cnt_reg, conv_cnt_next;
    logic [IDX_W-1:0] byte_idx_reg, byte_idx_next;
    logic [IDX_W-1:0] end_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            conv_cnt_reg <= '0;
            byte_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            conv_cnt_reg <= conv_cnt_next;
            byte_idx_reg <= byte_idx_next;
        end
    end

    assign end_idx = (sts.has_count ? SUM_POS_WITH_COUNT : SUM_POS_NO_COUNT) + 5'd1;

    always_comb
    begin
        state_next    = state_reg;
        conv_cnt_next = conv_cnt_reg;
        byte_idx_next = byte_idx_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.byte_idx  = byte_idx_reg;
        cmd.conv_idx  = conv_cnt_reg;
        cmd.wr_idx    = conv_cnt_reg - 2'd1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load      = 1'b1;
                    conv_cnt_next = '0;
                    state_next    = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv_go   = (conv_cnt_reg != CONV_LAST);
                cmd.wr_en     = (conv_cnt_reg != 2'd0);
                conv_cnt_next = conv_cnt_reg + 2'd1;
                if (conv_cnt_reg == CONV_LAST)
                begin
                    byte_idx_next = '0;
                    state_next    = ST_SEND;
                end
            end
            ST_SEND:
            begin
                cmd.emit = sts.out_free;
                if (sts.out_free)
                begin
                    byte_idx_next = byte_idx_reg + 5'd1;
                    if (byte_idx_reg == end_idx)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/tfp_datapath.sv
module tfp_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  tfp_pkg::cmd_t cmd,
    output tfp_pkg::sts_t sts,
    input  logic [7:0]    dest_address,
    input  logic [183:0]  in_data,
    input  logic [1:0]    in_user,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_data,
    output logic          out_last
);
    import tfp_pkg::*;

    logic [7:0]         frame_id_reg;
    logic               scale_reg;
    logic               has_count_reg;
    logic [VALUE_W-1:0] value_reg [NUM_VALS];
    logic [WORD_W-1:0]  held_words_reg [4];

    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic               neg_reg, neg_next;
    logic [VALUE_W-1:0] sel_value;
    logic [VALUE_W-1:0] mag;
    logic [PROD_W-FRAC_W-1:0] q;
    logic [WORD_W-1:0]  conv_word;

    logic [7:0]         sum_reg, sum_next;
    logic [7:0]         accum_reg, accum_next;
    logic               out_valid_reg;
    logic [7:0]         out_data_reg;
    logic               out_last_reg;

    logic [IDX_W-1:0]   sum_pos;
    logic [IDX_W-1:0]   off;
    logic [WORD_W-1:0]  cur_word;
    logic [7:0]         cur_byte;
    logic               cur_last;
    logic               is_data;

    assign sts.has_count = has_count_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            frame_id_reg      <= in_data[7:0];
            value_reg[0]      <= in_data[55:8];
            value_reg[1]      <= in_data[103:56];
            value_reg[2]      <= in_data[151:104];
            held_words_reg[3] <= in_data[183:152];
            scale_reg         <= in_user[0];
            has_count_reg     <= in_user[1];
        end
        if (cmd.conv_go)
        begin
            prod_reg <= prod_next;
            neg_reg  <= neg_next;
        end
        if (cmd.wr_en)
        begin
            held_words_reg[cmd.wr_idx] <= conv_word;
        end
    end

    always_comb
    begin
        case (cmd.conv_idx)
            2'd0:    sel_value = value_reg[0];
            2'd1:    sel_value = value_reg[1];
            default: sel_value = value_reg[2];
        endcase
        neg_next = sel_value[VALUE_W-1];
        mag      = neg_next ? (~sel_value + 1'b1) : sel_value;
        if (scale_reg)
        begin
            prod_next = PROD_W'(mag) * PROD_W'(SCALE_FACTOR);
        end
        else
        begin
            prod_next = PROD_W'(mag);
        end
    end

    always_comb
    begin
        q = prod_reg[PROD_W-1:FRAC_W];
        if (!neg_reg)
        begin
            conv_word = (q > (PROD_W-FRAC_W)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[WORD_W-1:0];
        end
        else
        begin
            conv_word = (q > (PROD_W-FRAC_W)'(32'h8000_0000)) ? 32'h8000_0000
                                                             : (32'd0 - q[WORD_W-1:0]);
        end
    end

    always_comb
    begin
        sum_pos  = has_count_reg ? SUM_POS_WITH_COUNT : SUM_POS_NO_COUNT;
        off      = cmd.byte_idx - HDR_BYTES;
        cur_word = held_words_reg[off[3:2]];
        is_data  = (cmd.byte_idx < sum_pos);
        cur_last = 1'b0;
        if (cmd.byte_idx == POS_HEAD)
        begin
            cur_byte = FRAME_HEAD;
        end
        else if (cmd.byte_idx == POS_DEST)
        begin
            cur_byte = dest_address;
        end
        else if (cmd.byte_idx == POS_ID)
        begin
            cur_byte = frame_id_reg;
        end
        else if (cmd.byte_idx == POS_LEN)
        begin
            cur_byte = has_count_reg ? LEN_WITH_COUNT : LEN_NO_COUNT;
        end
        else if (is_data)
        begin
            cur_byte = cur_word[8*off[1:0] +: 8];
        end
        else if (cmd.byte_idx == sum_pos)
        begin
            cur_byte = sum_reg;
        end
        else
        begin
            cur_byte = accum_reg;
            cur_last = 1'b1;
        end
        sum_next   = sum_reg + cur_byte;
        accum_next = accum_reg + sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            accum_reg     <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                sum_reg   <= '0;
                accum_reg <= '0;
            end
            else if (cmd.emit && is_data)
            begin
                sum_reg   <= sum_next;
                accum_reg <= accum_next;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= cur_byte;
            out_last_reg <= cur_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

// File: hw/rtl/telemetry_frame_packer.sv
// channel   direction  fields (low bit first)
// s_axis    in         tdata: frame_id, value_a, value_b, value_c, raw_count
//                      tuser: scale_by_hundred, has_count
// m_axis    out        tdata: tx_byte; tlast: last_byte
// cfg       in         data: dest_address
//
// A request is accepted, then its values are converted in turn through one shared
// multiply stage, then the frame goes out at one byte per cycle while the sink does
// not stall. s_axis_tready is high only between frames. Output stalls hold the byte
// sequencer; the output register drains while the next request converts. Reset
// clears control state and sets dest_address to 0xFF.
module telemetry_frame_packer (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [183:0] s_axis_tdata,   // frame_id, value_a, value_b, value_c, raw_count
    input  logic [1:0]   s_axis_tuser,   // scale_by_hundred, has_count
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,   // tx_byte
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data
);
    import tfp_pkg::*;

    cmd_t       cmd;
    sts_t       sts;
    logic [7:0] dest_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_reg <= DEST_RESET;
        end
        else if (cfg_valid)
        begin
            dest_reg <= cfg_data;
        end
    end

    tfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tfp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .dest_address (dest_reg),
        .in_data      (s_axis_tdata),
        .in_user      (s_axis_tuser),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata),
        .out_last     (m_axis_tlast)
    );

endmodule
